FILE: rtl/cct_pkg.sv
package cct_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int MAX_EVENTS = 4;
  localparam int EV_CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int EV_IDX_W = $clog2(MAX_EVENTS);

  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    KIND_ID   = 3'd0,
    KIND_NUM  = 3'd1,
    KIND_OP   = 3'd2,
    KIND_STR  = 3'd3,
    KIND_EOL  = 3'd4,
    KIND_NONE = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    EV_APPEND    = 2'd0,
    EV_CLOSE     = 2'd1,
    EV_BAD_CHAR  = 2'd2,
    EV_OPEN_LINE = 2'd3
  } ev_code_t;

  typedef struct packed {
    ev_code_t    code;
    kind_t       kind;
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        last;
  } event_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] quote;
    logic [7:0] prev;
    logic       line_has;
    logic       halted;
  } text_state_t;

endpackage

FILE: rtl/cct_classify.sv
module cct_classify
  import cct_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic [7:0]                    c,
  input  logic                          fin,
  input  text_state_t                   st,
  input  logic [POS_BITS-1:0]           pos,
  output text_state_t                   st_next,
  output logic [POS_BITS-1:0]           pos_next,
  output event_t [MAX_EVENTS-1:0]       evs,
  output logic [EV_CNT_W-1:0]           n_ev
);

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_opch(input logic [7:0] b);
    return (b inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_EQ});
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b inside {[8'd9:8'd13], CH_SPACE});
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return (b inside {CH_DQUOTE, CH_SQUOTE});
  endfunction

  function automatic event_t mk_ev(input ev_code_t code, input kind_t kind,
                                   input logic [7:0] ch, input logic [15:0] p);
    event_t e;
    e.code = code;
    e.kind = kind;
    e.ch   = ch;
    e.pos  = p;
    e.last = 1'b0;
    return e;
  endfunction

  logic [POS_BITS+15:0] pos_wide;
  logic [15:0]          pos16;
  logic                 pend;
  logic                 close_pre;
  logic                 app;
  kind_t                app_kind;
  logic                 close_post;
  kind_t                post_kind;
  kind_t                kind_new;
  logic                 eol;
  logic                 bad;
  logic                 line_new;
  logic                 open_line;
  logic [EV_CNT_W-1:0]  n;

  assign pos_wide = {16'b0, pos};
  assign pos16    = pos_wide[15:0];
  assign pend     = (st.kind != KIND_NONE);

  always_comb begin
    close_pre  = 1'b0;
    app        = 1'b0;
    app_kind   = KIND_STR;
    close_post = 1'b0;
    post_kind  = KIND_STR;
    kind_new   = st.kind;
    eol        = 1'b0;
    bad        = 1'b0;
    st_next    = st;
    if (is_ws(c) && st.kind != KIND_STR) begin
      close_pre = pend;
      kind_new  = KIND_NONE;
    end else if (is_quote(c)) begin
      app = 1'b1;
      if (st.kind != KIND_STR) begin
        close_pre     = pend;
        kind_new      = KIND_STR;
        st_next.quote = c;
      end else if (c == st.quote && st.prev != CH_BSLASH) begin
        close_post = 1'b1;
        kind_new   = KIND_NONE;
      end
    end else if (st.kind == KIND_STR) begin
      app = 1'b1;
    end else if (is_alpha(c) || (is_digit(c) && st.kind == KIND_ID)) begin
      app       = 1'b1;
      app_kind  = KIND_ID;
      close_pre = pend && st.kind != KIND_ID;
      kind_new  = KIND_ID;
    end else if (is_digit(c) || (st.kind == KIND_NUM && c == CH_DOT)) begin
      app       = 1'b1;
      app_kind  = KIND_NUM;
      close_pre = pend && st.kind != KIND_NUM;
      kind_new  = KIND_NUM;
    end else if (is_opch(c)) begin
      app       = 1'b1;
      app_kind  = KIND_OP;
      close_pre = pend && st.kind != KIND_OP;
      kind_new  = KIND_OP;
    end else if (c == CH_SEMI) begin
      app        = 1'b1;
      app_kind   = KIND_EOL;
      close_pre  = pend;
      close_post = 1'b1;
      post_kind  = KIND_EOL;
      kind_new   = KIND_NONE;
      eol        = 1'b1;
    end else begin
      bad = 1'b1;
    end

    line_new  = eol ? 1'b0 : (st.line_has || close_pre || close_post);
    open_line = fin && (line_new || kind_new != KIND_NONE);

    evs      = '0;
    n        = '0;
    pos_next = pos;
    if (!st.halted) begin
      if (bad) begin
        evs[0]         = mk_ev(EV_BAD_CHAR, KIND_ID, c, pos16);
        n              = EV_CNT_W'(1);
        st_next.halted = 1'b1;
      end else begin
        if (close_pre) begin
          evs[n[EV_IDX_W-1:0]] = mk_ev(EV_CLOSE, st.kind, 8'h00, pos16);
          n = n + 1'b1;
        end
        if (app) begin
          evs[n[EV_IDX_W-1:0]] = mk_ev(EV_APPEND, app_kind, c, pos16);
          n = n + 1'b1;
        end
        if (close_post) begin
          evs[n[EV_IDX_W-1:0]] = mk_ev(EV_CLOSE, post_kind, 8'h00, pos16);
          n = n + 1'b1;
        end
        if (open_line) begin
          evs[n[EV_IDX_W-1:0]] = mk_ev(EV_OPEN_LINE, KIND_ID, 8'h00, pos16);
          n = n + 1'b1;
        end
        st_next.kind     = kind_new;
        st_next.line_has = line_new;
        st_next.prev     = c;
        pos_next         = (pos == '1) ? pos : POS_BITS'(pos + 1'b1);
        if (fin) begin
          st_next.kind     = KIND_NONE;
          st_next.quote    = 8'h00;
          st_next.prev     = 8'h00;
          st_next.line_has = 1'b0;
          pos_next         = '0;
        end
      end
      if (n != '0) begin
        evs[EV_IDX_W'(n - 1'b1)].last = 1'b1;
      end
    end
    n_ev = n;
  end

endmodule

FILE: rtl/cct_evq.sv
module cct_evq
  import cct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  event_t [MAX_EVENTS-1:0] evs,
  input  logic [EV_CNT_W-1:0]     n_ev,
  input  logic                    pop_ready,
  output logic                    can_load,
  output logic                    head_valid,
  output event_t                  head
);

  event_t [MAX_EVENTS-1:0] slots;
  logic [EV_CNT_W-1:0]     rem;
  logic [EV_IDX_W-1:0]     rd;
  logic                    pop;

  assign head_valid = (rem != '0);
  assign head       = slots[rd];
  assign pop        = head_valid && pop_ready;
  assign can_load   = (rem == '0) || (rem == EV_CNT_W'(1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      rd  <= '0;
    end else if (load) begin
      rem <= n_ev;
      rd  <= '0;
    end else if (pop) begin
      rem <= EV_CNT_W'(rem - 1'b1);
      rd  <= EV_IDX_W'(rd + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= evs;
    end
  end

endmodule

FILE: rtl/char_class_tokenizer_core.sv
// The first event of an accepted byte is offered on the master side in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one event and m_tready is high;
// a byte that gives more events holds the event buffer, and the next byte waits until its last event is taken.
// The event buffer drains one transfer per cycle while m_tready is high and is refilled in the cycle it empties.
// Reset (rst, synchronous, active high) clears the token state, the position and the halt
// flag and empties the event buffer; no clearing pass is needed.
module char_class_tokenizer_core
  import cct_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] char_out, [23:8] position
  output logic [4:0]  m_tuser,   // [1:0] event_res, [4:2] token_kind
  output logic        m_tlast
);

  text_state_t             state;
  text_state_t             state_next;
  logic [POS_BITS-1:0]     pos;
  logic [POS_BITS-1:0]     pos_next;
  event_t [MAX_EVENTS-1:0] evs;
  logic [EV_CNT_W-1:0]     n_ev;
  logic                    load;
  event_t                  head;

  assign load = s_tvalid && s_tready;

  cct_classify #(
    .POS_BITS(POS_BITS)
  ) u_classify (
    .c        (s_tdata),
    .fin      (s_tlast),
    .st       (state),
    .pos      (pos),
    .st_next  (state_next),
    .pos_next (pos_next),
    .evs      (evs),
    .n_ev     (n_ev)
  );

  cct_evq u_evq (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .evs        (evs),
    .n_ev       (n_ev),
    .pop_ready  (m_tready),
    .can_load   (s_tready),
    .head_valid (m_tvalid),
    .head       (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.kind     <= KIND_NONE;
      state.quote    <= 8'h00;
      state.prev     <= 8'h00;
      state.line_has <= 1'b0;
      state.halted   <= 1'b0;
      pos            <= '0;
    end else if (load) begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  assign m_tdata = {head.pos, head.ch};
  assign m_tuser = {head.kind, head.code};
  assign m_tlast = head.last;

  a_bad_char_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == EV_BAD_CHAR |-> m_tlast)
    else $error("Unknown-character event is not the last of its run.");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    state.halted && load |-> n_ev == '0)
    else $error("Halted tokenizer produced events.");

  a_ready_on_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tready && m_tlast)
    else $error("Input taken while a run of events is still pending.");

endmodule
